// File: src/button_click_autorepeat_defines.svh
// -----------------------------------------------------------------------------
// Button click autorepeat: assertion macros
// Shared property wrappers; each expects clk_i and rst_ni in scope.
// -----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_AUTOREPEAT_DEFINES_SVH
`define BUTTON_CLICK_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication.
`define BCA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bca_pkg.sv
// -----------------------------------------------------------------------------
// Button click autorepeat package
// Field widths, register indexes, opcodes and shared types.
// -----------------------------------------------------------------------------
package bca_pkg;

  localparam int unsigned FieldW      = 16;
  localparam int unsigned DelayW      = 15;
  localparam int unsigned CountW      = 16;
  localparam int unsigned ButtonBits  = 16;
  localparam int unsigned RepeatSlots = 4;
  localparam int unsigned NumKeyRegs  = 4;
  localparam int unsigned CfgIdxW     = 4;

  // Opcodes
  localparam logic OpTick = 1'b0;
  localparam logic OpPoll = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegActiveLevel  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegSamplePeriod = 4'd1;
  localparam logic [CfgIdxW-1:0] RegRepeatDelay  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegRepeatPeriod = 4'd3;
  localparam logic [CfgIdxW-1:0] RegRepeatKey0   = 4'd4;

  typedef struct packed {
    logic              opcode;
    logic [FieldW-1:0] raw_buttons;
  } bca_in_t;

  typedef struct packed {
    logic [FieldW-1:0] clicks;
    logic [FieldW-1:0] repeat_clicks;
    logic [FieldW-1:0] button_state;
  } bca_out_t;

  typedef struct packed {
    logic                              active_level;
    logic [FieldW-1:0]                 sample_period;
    logic [DelayW-1:0]                 repeat_delay;
    logic [DelayW-1:0]                 repeat_period;
    logic [NumKeyRegs-1:0][FieldW-1:0] repeat_key;
  } bca_cfg_t;

  typedef struct packed {
    logic tick;
    logic poll;
  } bca_evt_t;

  localparam bca_cfg_t CfgReset = '{
    active_level:  1'b0,
    sample_period: 16'd10,
    repeat_delay:  15'd500,
    repeat_period: 15'd100,
    repeat_key:    '0
  };

endpackage

// File: src/button_click_autorepeat.sv
// -----------------------------------------------------------------------------
// Button click autorepeat top level
// A result is valid once registered; the beat passes the input reg, then the result reg.
// Throughput: one tick or poll per unstalled cycle; the single-pass update closes the state.
// Reset: flags, state, counters and config clear asynchronously; prescaler resets to zero.
// -----------------------------------------------------------------------------
`include "button_click_autorepeat_defines.svh"

module button_click_autorepeat #(
  parameter int unsigned BUTTON_BITS  = bca_pkg::ButtonBits,
  parameter int unsigned REPEAT_SLOTS = bca_pkg::RepeatSlots
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bca_pkg::bca_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bca_pkg::bca_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bca_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bca_pkg::FieldW-1:0]  cfg_data_i
);

  localparam int unsigned FieldW  = bca_pkg::FieldW;
  localparam int unsigned SampleW = (BUTTON_BITS < FieldW) ? BUTTON_BITS : FieldW;

  bca_pkg::bca_cfg_t  cfg;
  bca_pkg::bca_evt_t  evt;
  bca_pkg::bca_in_t   in_q;
  bca_pkg::bca_out_t  out_q, out_d;
  logic               in_valid_q, out_valid_q;
  logic               advance, process;
  logic [SampleW-1:0] cur, cur_next, pending, repeats;

  // advance when the result register is empty or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  assign evt.tick = process && (in_q.opcode == bca_pkg::OpTick);
  assign evt.poll = process && (in_q.opcode == bca_pkg::OpPoll);

  bca_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bca_sampler #(
    .BUTTON_BITS (BUTTON_BITS)
  ) u_sampler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt),
    .raw_i      (in_q.raw_buttons),
    .cfg_i      (cfg),
    .cur_o      (cur),
    .cur_next_o (cur_next),
    .pending_o  (pending)
  );

  bca_repeat #(
    .BUTTON_BITS  (BUTTON_BITS),
    .REPEAT_SLOTS (REPEAT_SLOTS)
  ) u_repeat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (evt),
    .cfg_i     (cfg),
    .cur_i     (cur),
    .repeats_o (repeats)
  );

  always_comb begin
    out_d.button_state  = FieldW'(cur_next);
    out_d.clicks        = '0;
    out_d.repeat_clicks = '0;
    if (evt.poll) begin
      out_d.clicks        = FieldW'(pending | repeats);
      out_d.repeat_clicks = FieldW'(repeats);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (process) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BCA_ASSERT_IMPL(a_rep_subset, out_valid_o, (out_data_o.repeat_clicks & ~out_data_o.clicks) == '0, "repeat click missing from clicks")
  `BCA_ASSERT_NEXT(a_result_follows, process, out_valid_q, "processed beat left no result")

endmodule

// File: src/bca_cfg_regs.sv
// -----------------------------------------------------------------------------
// Button click autorepeat configuration registers
// Register file written through the index/data write channel.
// -----------------------------------------------------------------------------
module bca_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bca_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bca_pkg::FieldW-1:0]   cfg_data_i,
  output bca_pkg::bca_cfg_t            cfg_o
);

  bca_pkg::bca_cfg_t cfg_q, cfg_d;
  logic              cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        bca_pkg::RegActiveLevel:  cfg_d.active_level  = cfg_data_i[0];
        bca_pkg::RegSamplePeriod: cfg_d.sample_period = cfg_data_i;
        bca_pkg::RegRepeatDelay:  cfg_d.repeat_delay  = cfg_data_i[bca_pkg::DelayW-1:0];
        bca_pkg::RegRepeatPeriod: cfg_d.repeat_period = cfg_data_i[bca_pkg::DelayW-1:0];
        default: begin
          // key masks; indexes past the last key fall through untouched
          for (int k = 0; k < bca_pkg::NumKeyRegs; k++) begin
            if (cfg_index_i == bca_pkg::RegRepeatKey0 + bca_pkg::CfgIdxW'(k)) begin
              cfg_d.repeat_key[k] = cfg_data_i;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bca_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/bca_sampler.sv
// -----------------------------------------------------------------------------
// Button click autorepeat sampler
// Prescaler, sampled button word and pending edge-click mask.
// -----------------------------------------------------------------------------
`include "button_click_autorepeat_defines.svh"

module bca_sampler #(
  parameter int unsigned BUTTON_BITS = bca_pkg::ButtonBits,
  localparam int unsigned SampleW =
    (BUTTON_BITS < bca_pkg::FieldW) ? BUTTON_BITS : bca_pkg::FieldW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bca_pkg::bca_evt_t          evt_i,
  input  logic [bca_pkg::FieldW-1:0] raw_i,
  input  bca_pkg::bca_cfg_t          cfg_i,
  output logic [SampleW-1:0]         cur_o,
  output logic [SampleW-1:0]         cur_next_o,
  output logic [SampleW-1:0]         pending_o
);

  // cur_q also serves as the previous sample: both always take the same word
  logic [SampleW-1:0]         cur_q, cur_d;
  logic [SampleW-1:0]         pend_q, pend_d;
  logic [bca_pkg::FieldW-1:0] presc_q, presc_d;
  logic [SampleW-1:0]         sample;
  logic [SampleW-1:0]         pressed;

  assign sample  = raw_i[SampleW-1:0];
  assign pressed = cfg_i.active_level ? sample : ~sample;

  always_comb begin
    cur_d   = cur_q;
    pend_d  = pend_q;
    presc_d = presc_q;
    if (evt_i.tick) begin
      if (presc_q == '0) begin
        pend_d  = pend_q | ((sample ^ cur_q) & pressed);
        cur_d   = sample;
        presc_d = cfg_i.sample_period;
      end else begin
        presc_d = presc_q - bca_pkg::FieldW'(1);
      end
    end else if (evt_i.poll) begin
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      pend_q  <= '0;
      presc_q <= '0;
    end else begin
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      presc_q <= presc_d;
    end
  end

  assign cur_o      = cur_q;
  assign cur_next_o = cur_d;
  assign pending_o  = pend_q;

  `BCA_ASSERT_NEXT(a_presc_reload, evt_i.tick && presc_q == '0, presc_q == $past(cfg_i.sample_period), "prescaler not reloaded after sample")
  `BCA_ASSERT_NEXT(a_pend_clear, evt_i.poll, pend_q == '0, "pending clicks survived a poll")

endmodule

// File: src/bca_repeat.sv
// -----------------------------------------------------------------------------
// Button click autorepeat slots
// Per-slot hold counters that inject repeat clicks on polls.
// -----------------------------------------------------------------------------
`include "button_click_autorepeat_defines.svh"

module bca_repeat #(
  parameter int unsigned BUTTON_BITS  = bca_pkg::ButtonBits,
  parameter int unsigned REPEAT_SLOTS = bca_pkg::RepeatSlots,
  localparam int unsigned SampleW =
    (BUTTON_BITS < bca_pkg::FieldW) ? BUTTON_BITS : bca_pkg::FieldW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bca_pkg::bca_evt_t  evt_i,
  input  bca_pkg::bca_cfg_t  cfg_i,
  input  logic [SampleW-1:0] cur_i,
  output logic [SampleW-1:0] repeats_o
);

  localparam int unsigned CountW = bca_pkg::CountW;
  localparam int unsigned DelayW = bca_pkg::DelayW;

  logic [REPEAT_SLOTS-1:0][CountW-1:0]  cnt_q, cnt_d;
  logic [REPEAT_SLOTS-1:0][SampleW-1:0] slot_keys;
  logic [REPEAT_SLOTS-1:0]              fire;
  logic [CountW-1:0]                    limit;
  logic [CountW-1:0]                    delay_ext;

  assign delay_ext = CountW'(cfg_i.repeat_delay);
  assign limit     = delay_ext + CountW'(cfg_i.repeat_period);

  for (genvar k = 0; k < REPEAT_SLOTS; k++) begin : g_slot
    logic              en;
    logic              held;
    logic [CountW-1:0] inc;

    assign slot_keys[k] = cfg_i.repeat_key[k][SampleW-1:0];
    assign en           = |slot_keys[k];
    assign held = cfg_i.active_level ? ((cur_i & slot_keys[k]) == slot_keys[k])
                                     : ((cur_i & slot_keys[k]) == '0);
    // saturate at all ones
    assign inc     = (cnt_q[k] != '1) ? cnt_q[k] + CountW'(1) : cnt_q[k];
    assign fire[k] = evt_i.poll & en & held & (inc >= limit);

    always_comb begin
      cnt_d[k] = cnt_q[k];
      if (evt_i.poll && en) begin
        if (!held) begin
          cnt_d[k] = '0;
        end else if (fire[k]) begin
          cnt_d[k] = delay_ext;
        end else begin
          cnt_d[k] = inc;
        end
      end
    end
  end

  always_comb begin
    repeats_o = '0;
    for (int k = 0; k < REPEAT_SLOTS; k++) begin
      if (fire[k]) begin
        repeats_o = repeats_o | slot_keys[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `BCA_ASSERT_NEXT(a_slot0_reload, fire[0], cnt_q[0][DelayW-1:0] == $past(cfg_i.repeat_delay) && !cnt_q[0][CountW-1], "slot 0 count not dropped to delay")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Button click autorepeat testbench
// Drives ticks and polls through the valid/stall input channel, with bursty
// sending and a patterned output stall. Every accepted beat runs through an
// in-bench model of the prescaler, click edges and repeat slots. Each result
// is checked field by field, in order. Register settings change only while the
// block is drained: a directed table first, then random phases.
// -----------------------------------------------------------------------------
module tb;

  localparam int unsigned FieldW     = bca_pkg::FieldW;
  localparam int unsigned DelayW     = bca_pkg::DelayW;
  localparam int unsigned CountW     = bca_pkg::CountW;
  localparam int unsigned CfgIdxW    = bca_pkg::CfgIdxW;
  localparam int unsigned NumKeyRegs = bca_pkg::NumKeyRegs;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    index;
    logic [FieldW-1:0]     value;
    bca_pkg::bca_in_t      beat;
    bit                    typed;
    bca_pkg::bca_out_t     want;
  } stim_row_t;

  // Index past the register map; a write there must be dropped.
  localparam logic [CfgIdxW-1:0] RegUnused = 4'd15;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bca_pkg::bca_in_t   in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bca_pkg::bca_out_t  out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [FieldW-1:0]  cfg_data = '0;

  button_click_autorepeat uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("tb NOT OK");
    $finish;
  end

  // Shadow registers and state of the click detector
  logic              lvl_active;
  logic [FieldW-1:0] per_sample;
  logic [DelayW-1:0] rep_delay;
  logic [DelayW-1:0] rep_period;
  logic [FieldW-1:0] key_mask [NumKeyRegs];
  logic [FieldW-1:0] cur_sample;
  logic [FieldW-1:0] prev_sample;
  logic [FieldW-1:0] pending_clicks;
  logic [FieldW-1:0] prescale;
  logic [CountW-1:0] hold_count [NumKeyRegs];

  bca_pkg::bca_out_t clicks_q[$];
  bca_pkg::bca_out_t head;

  int n_ticks = 0;
  int n_polls = 0;
  int n_repeat_beats = 0;
  int n_settings = 0;
  int n_fail = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  int stall_mode = 0;
  int stall_left = 0;

  task automatic apply_event(input bca_pkg::bca_in_t beat, output bca_pkg::bca_out_t res);
    logic [FieldW-1:0] s;
    logic [FieldW-1:0] repeats;
    logic              held;
    int                limit;
    repeats = '0;
    res = '0;
    if (beat.opcode == bca_pkg::OpTick) begin
      if (prescale == 0) begin
        s = beat.raw_buttons;
        pending_clicks |= (s ^ prev_sample) & (lvl_active ? s : ~s);
        cur_sample = s;
        prev_sample = s;
        prescale = per_sample;
      end else begin
        prescale--;
      end
    end else begin
      limit = int'(rep_delay) + int'(rep_period);
      res.clicks = pending_clicks;
      pending_clicks = '0;
      for (int k = 0; k < bca_pkg::RepeatSlots; k++) begin
        if (key_mask[k] != 0) begin
          held = lvl_active ? ((cur_sample & key_mask[k]) == key_mask[k])
                            : ((cur_sample & key_mask[k]) == 0);
          if (held) begin
            if (hold_count[k] != {CountW{1'b1}}) hold_count[k]++;
            // fall back to the delay so the next repeat is one period away
            if (int'(hold_count[k]) >= limit) begin
              hold_count[k] = CountW'(rep_delay);
              repeats |= key_mask[k];
            end
          end else begin
            hold_count[k] = '0;
          end
        end
      end
      res.clicks |= repeats;
      res.repeat_clicks = repeats;
    end
    res.button_state = cur_sample;
  endtask

  task automatic send_beat(input bca_pkg::bca_in_t beat, input bit typed,
                           input bca_pkg::bca_out_t want);
    bca_pkg::bca_out_t res;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    apply_event(beat, res);
    clicks_q.push_back(typed ? want : res);
    if (beat.opcode == bca_pkg::OpTick) n_ticks++;
    else n_polls++;
  endtask

  // Open a new burst, with a random gap in front unless the phase runs steady.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (clicks_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [FieldW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      bca_pkg::RegActiveLevel:  lvl_active = value[0];
      bca_pkg::RegSamplePeriod: per_sample = value;
      bca_pkg::RegRepeatDelay:  rep_delay  = value[DelayW-1:0];
      bca_pkg::RegRepeatPeriod: rep_period = value[DelayW-1:0];
      default: begin
        if (index >= bca_pkg::RegRepeatKey0 && index < bca_pkg::RegRepeatKey0 + NumKeyRegs)
          key_mask[index - bca_pkg::RegRepeatKey0] = value;
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly narrow masks so that holds happen; some disabled, some all keys.
  function automatic logic [FieldW-1:0] pick_keys();
    logic [FieldW-1:0] m;
    int                r;
    r = $urandom_range(0, 9);
    m = '0;
    if (r == 2) m = '1;
    else if (r > 2) repeat ($urandom_range(1, 3)) m |= FieldW'(1) << $urandom_range(0, 15);
    return m;
  endfunction

  task automatic write_setting(input logic lvl, input logic [FieldW-1:0] sp,
                               input logic [DelayW-1:0] dly, input logic [DelayW-1:0] per);
    write_reg(bca_pkg::RegActiveLevel, FieldW'(lvl));
    write_reg(bca_pkg::RegSamplePeriod, sp);
    write_reg(bca_pkg::RegRepeatDelay, FieldW'(dly));
    write_reg(bca_pkg::RegRepeatPeriod, FieldW'(per));
    for (int k = 0; k < NumKeyRegs; k++) begin
      write_reg(bca_pkg::RegRepeatKey0 + CfgIdxW'(k), pick_keys());
    end
    n_settings++;
  endtask

  function automatic stim_row_t beat_row(logic op, logic [FieldW-1:0] raw);
    stim_row_t row;
    row = '{kind: RowItem, index: '0, value: '0, beat: '{op, raw}, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic op, logic [FieldW-1:0] raw,
                                          logic [FieldW-1:0] c, logic [FieldW-1:0] r,
                                          logic [FieldW-1:0] s);
    stim_row_t row;
    row = beat_row(op, raw);
    row.typed = 1'b1;
    row.want = '{c, r, s};
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [FieldW-1:0] val);
    stim_row_t row;
    row = '{kind: RowCfg, index: idx, value: val, beat: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  // Output side stalls on a pattern that switches mode now and then.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (clicks_q.size() == 0) begin
        $display("%0t: unexpected beat clicks=%h repeat=%h state=%h", $time,
                 out_data.clicks, out_data.repeat_clicks, out_data.button_state);
        n_fail++;
      end else begin
        head = clicks_q.pop_front();
        if (out_data.clicks !== head.clicks || out_data.repeat_clicks !== head.repeat_clicks ||
            out_data.button_state !== head.button_state) begin
          $display("%0t: mismatch clicks exp %h got %h, repeat exp %h got %h, state exp %h got %h",
                   $time, head.clicks, out_data.clicks, head.repeat_clicks,
                   out_data.repeat_clicks, head.button_state, out_data.button_state);
          n_fail++;
        end
        if (out_data.repeat_clicks != 0) n_repeat_beats++;
      end
    end
  end

  initial begin
    stim_row_t         rows[$];
    bca_pkg::bca_in_t  beat;
    logic [FieldW-1:0] hold_word;
    int                r;
    int                bit_pos;
    bit                quiet;

    lvl_active     = bca_pkg::CfgReset.active_level;
    per_sample     = bca_pkg::CfgReset.sample_period;
    rep_delay      = bca_pkg::CfgReset.repeat_delay;
    rep_period     = bca_pkg::CfgReset.repeat_period;
    cur_sample     = '0;
    prev_sample    = '0;
    pending_clicks = '0;
    prescale       = '0;
    for (int k = 0; k < NumKeyRegs; k++) begin
      key_mask[k]   = bca_pkg::CfgReset.repeat_key[k];
      hold_count[k] = '0;
    end
    hold_word = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: nothing pending, nothing sampled.
    rows.push_back(typed_row(bca_pkg::OpPoll, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Active high, every tick samples, zero delay and zero period.
    rows.push_back(reg_row(bca_pkg::RegActiveLevel, 16'd1));
    rows.push_back(reg_row(bca_pkg::RegSamplePeriod, 16'd0));
    rows.push_back(reg_row(bca_pkg::RegRepeatDelay, 16'd0));
    rows.push_back(reg_row(bca_pkg::RegRepeatPeriod, 16'd0));
    rows.push_back(reg_row(bca_pkg::RegRepeatKey0, 16'h0001));
    rows.push_back(reg_row(bca_pkg::RegRepeatKey0 + 4'd3, 16'hFFFF));
    rows.push_back(typed_row(bca_pkg::OpTick, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    rows.push_back(typed_row(bca_pkg::OpTick, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
    rows.push_back(beat_row(bca_pkg::OpPoll, 16'h0000));
    rows.push_back(beat_row(bca_pkg::OpPoll, 16'hFFFF));
    rows.push_back(beat_row(bca_pkg::OpTick, 16'h0001));
    rows.push_back(beat_row(bca_pkg::OpPoll, 16'h0000));
    rows.push_back(beat_row(bca_pkg::OpTick, 16'h8000));
    rows.push_back(beat_row(bca_pkg::OpPoll, 16'h0000));
    rows.push_back(beat_row(bca_pkg::OpPoll, 16'h0000));
    // Active low, thinned sampling, long threshold, then lower it mid-hold.
    rows.push_back(reg_row(bca_pkg::RegActiveLevel, 16'd0));
    rows.push_back(reg_row(bca_pkg::RegSamplePeriod, 16'd3));
    rows.push_back(reg_row(bca_pkg::RegRepeatDelay, 16'd20));
    rows.push_back(reg_row(bca_pkg::RegRepeatPeriod, 16'd20));
    rows.push_back(reg_row(bca_pkg::RegRepeatKey0, 16'h0000));
    rows.push_back(reg_row(bca_pkg::RegRepeatKey0 + 4'd1, 16'h00F0));
    rows.push_back(reg_row(bca_pkg::RegRepeatKey0 + 4'd2, 16'h0F00));
    rows.push_back(reg_row(bca_pkg::RegRepeatKey0 + 4'd3, 16'h0000));
    rows.push_back(reg_row(RegUnused, 16'hFFFF));
    rows.push_back(beat_row(bca_pkg::OpTick, 16'h0000));
    repeat (5) rows.push_back(beat_row(bca_pkg::OpPoll, 16'h0000));
    rows.push_back(reg_row(bca_pkg::RegRepeatDelay, 16'd1));
    rows.push_back(reg_row(bca_pkg::RegRepeatPeriod, 16'd1));
    repeat (2) rows.push_back(beat_row(bca_pkg::OpPoll, 16'h0000));
    repeat (4) rows.push_back(beat_row(bca_pkg::OpTick, 16'hFFFF));
    rows.push_back(beat_row(bca_pkg::OpPoll, 16'h0000));

    quiet = 1'b1;
    foreach (rows[i]) begin
      if (rows[i].kind == RowCfg) begin
        if (!quiet) settle();
        if (!quiet || i == 0 || rows[i-1].kind != RowCfg) n_settings++;
        quiet = 1'b1;
        write_reg(rows[i].index, rows[i].value);
      end else begin
        quiet = 1'b0;
        pace();
        send_beat(rows[i].beat, rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: write_setting(1'b0, 16'd0, 15'd0, 15'd1);
        1: write_setting(1'b1, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        default: write_setting(1'($urandom_range(0, 1)),
                               FieldW'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                            : $urandom_range(4, 20)),
                               DelayW'($urandom_range(0, 6)), DelayW'($urandom_range(0, 4)));
      endcase
      steady = (p == 3 || p == 6);
      for (int n = 0; n < 232; n++) begin
        // hold a button word for a while so repeat slots get to count
        r = $urandom_range(0, 99);
        bit_pos = $urandom_range(0, 15);
        if (r < 4) hold_word = FieldW'($urandom);
        else if (r < 9) hold_word = lvl_active ? '1 : '0;
        else if (r < 11) hold_word = lvl_active ? '0 : '1;
        else if (r < 22) hold_word[bit_pos] = ~hold_word[bit_pos];
        beat.opcode = ($urandom_range(0, 2) == 0) ? bca_pkg::OpPoll : bca_pkg::OpTick;
        beat.raw_buttons = ($urandom_range(0, 19) == 0) ? FieldW'($urandom) : hold_word;
        pace();
        send_beat(beat, 1'b0, '0);
      end
    end

    settle();
    $display("Covered %0d ticks and %0d polls over %0d register settings;", n_ticks, n_polls,
             n_settings);
    $display("%0d poll results carried autorepeat clicks.", n_repeat_beats);
    if (n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
